// File: rtl/scsa_pkg.sv
// shared types, constants and class tables for the size-class slab allocator
// no dependencies
package scsa_pkg;

	localparam int PAGES          = 64;
	localparam int PAGE_BYTES     = 4096;
	localparam int HEADER_BYTES   = 64;
	localparam int NUM_CLASSES    = 14;
	localparam int SLOTS_MAX      = 256;
	localparam int WORDS_PER_PAGE = (SLOTS_MAX + 63) / 64;
	localparam int USABLE_BYTES   = PAGE_BYTES - HEADER_BYTES;

	localparam int PAGE_W  = 6;
	localparam int WSEL_W  = 2;
	localparam int WADDR_W = PAGE_W + WSEL_W;
	localparam int OFF_W   = 12;
	localparam int CLS_W   = 4;
	localparam int BYTES_W = 11;
	localparam int SLOTS_W = 9;
	localparam int SLOT_W  = 8;
	localparam int SIZE_W  = 32;

	localparam logic [BYTES_W-1:0] MAX_SMALL_RESET = 11'd1056;
	localparam logic [SIZE_W-1:0]  MIN_REQ         = 32'd16;

	typedef enum logic [1:0] {
		ST_OK,
		ST_TOO_LARGE,
		ST_NO_PAGE,
		ST_NOT_OWNED
	} status_t;

	typedef enum logic {
		CMD_ALLOC,
		CMD_FREE
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_W_RD,
		S_W_CHK,
		S_CLAIM,
		S_F_META,
		S_F_DIV,
		S_F_RD,
		S_F_CHK,
		S_RES
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [SIZE_W-1:0]  req_size;
		logic [PAGE_W-1:0]  free_page;
		logic [OFF_W-1:0]   free_offset;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [PAGE_W-1:0]  page_index;
		logic [OFF_W-1:0]   byte_offset;
		logic [CLS_W-1:0]   size_class;
		logic [BYTES_W-1:0] slot_bytes;
		logic               page_released;
	} res_t;

	typedef struct packed {
		logic [CLS_W-1:0]   cls;
		logic [SLOTS_W-1:0] used;
	} meta_t;

	typedef struct packed {
		logic               start;
		logic [OFF_W-1:0]   dividend;
		logic [BYTES_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [OFF_W-1:0]   quot;
		logic [BYTES_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
		logic [BYTES_W-1:0] b;
		unique case (c)
			4'd0:    b = 11'd16;
			4'd1:    b = 11'd24;
			4'd2:    b = 11'd32;
			4'd3:    b = 11'd48;
			4'd4:    b = 11'd64;
			4'd5:    b = 11'd96;
			4'd6:    b = 11'd128;
			4'd7:    b = 11'd192;
			4'd8:    b = 11'd256;
			4'd9:    b = 11'd384;
			4'd10:   b = 11'd512;
			4'd11:   b = 11'd768;
			4'd12:   b = 11'd1024;
			4'd13:   b = 11'd1536;
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [SLOTS_W-1:0] class_slots(input logic [CLS_W-1:0] c);
		int n;
		unique case (c)
			4'd0:    n = USABLE_BYTES / 16;
			4'd1:    n = USABLE_BYTES / 24;
			4'd2:    n = USABLE_BYTES / 32;
			4'd3:    n = USABLE_BYTES / 48;
			4'd4:    n = USABLE_BYTES / 64;
			4'd5:    n = USABLE_BYTES / 96;
			4'd6:    n = USABLE_BYTES / 128;
			4'd7:    n = USABLE_BYTES / 192;
			4'd8:    n = USABLE_BYTES / 256;
			4'd9:    n = USABLE_BYTES / 384;
			4'd10:   n = USABLE_BYTES / 512;
			4'd11:   n = USABLE_BYTES / 768;
			4'd12:   n = USABLE_BYTES / 1024;
			4'd13:   n = USABLE_BYTES / 1536;
			default: n = 0;
		endcase
		if (int'(c) >= NUM_CLASSES || PAGE_BYTES <= HEADER_BYTES)
			n = 0;
		if (n > SLOTS_MAX)
			n = SLOTS_MAX;
		return SLOTS_W'(n);
	endfunction

endpackage

// File: rtl/scsa_stream_if.sv
// valid/ready channel carrying one payload of type T
// no dependencies
interface scsa_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/scsa_div.sv
// restoring divider, one quotient bit per cycle, for slot index of a free
// depends on scsa_pkg
module scsa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  scsa_pkg::div_req_t  ctl,
	output scsa_pkg::div_rsp_t  rsp
);
	import scsa_pkg::*;

	localparam int CNT_W = $clog2(OFF_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [OFF_W-1:0]   quo_q;
	logic [BYTES_W-1:0] rem_q;
	logic [BYTES_W-1:0] dvs_q;
	logic [BYTES_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, quo_q[OFF_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(OFF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= ctl.dividend;
			rem_q <= '0;
			dvs_q <= ctl.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= BYTES_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[OFF_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[BYTES_W-1:0];
				quo_q <= {quo_q[OFF_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	a_div_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	a_div_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dvs_q != '0) |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// File: rtl/size_class_slab_allocator_unit.sv
// size-class slab allocator top level: sequencer, page metadata and slot bitmaps
// depends on scsa_pkg, scsa_stream_if and scsa_div
//
//  channel  dir  payload  handshake
//  req      in   req_t    valid/ready, one allocate or free request
//  res      out  res_t    valid/ready, one result per request
//  cfg      in   11 bit   valid/ready, max_small_size write, always ready
//
// allocate: scans up to 64 pages for one of its class with room, then reads up to 4
// bitmap words of that page, and claims a free page when none has room
// free: runs the 12-step serial divider to find the slot index
// reset clears page use and bitmap word valid bits at once, no clearing pass
// a waiting result does not block the next request until that one finishes
module size_class_slab_allocator_unit (
	input logic             clk,
	input logic             arst_n,
	scsa_stream_if.sink     req,
	scsa_stream_if.source   res,
	scsa_stream_if.sink     cfg
);
	import scsa_pkg::*;

	localparam int NWORDS = PAGES * WORDS_PER_PAGE;

	state_t state_q, state_d;

	logic [BYTES_W-1:0] max_small_q;
	logic [PAGES-1:0]   page_in_use_q;
	logic [NWORDS-1:0]  bm_valid_q;

	meta_t meta_mem [PAGES];
	meta_t meta_rd_q;
	logic [PAGE_W-1:0] meta_raddr;
	logic              meta_we;
	meta_t             meta_wdata;

	logic [63:0] bm_mem [NWORDS];
	logic [63:0] bm_rd_q;
	logic        bm_rvld_q;
	logic [WADDR_W-1:0] bm_raddr;
	logic               bm_we;
	logic [WADDR_W-1:0] bm_waddr;
	logic [63:0]        bm_wdata;

	logic [CLS_W-1:0]  cls_q;
	logic [PAGE_W-1:0] p_q;
	logic [WSEL_W-1:0] w_q;
	logic [OFF_W-1:0]  off_q;
	logic [OFF_W-1:0]  slot_q;
	logic [BYTES_W-1:0] rem_q;

	res_t res_q, res_d, out_q;
	logic out_valid_q;
	logic res_load;

	div_req_t div_ctl;
	div_rsp_t div_rsp;

	// request decode
	logic              acc;
	logic [SIZE_W-1:0] sz_eff;
	logic              cls_hit;
	logic [CLS_W-1:0]  cls_sel;
	logic              alloc_bad;

	logic [BYTES_W-1:0] cur_bytes;
	logic [SLOTS_W-1:0] cur_slots;
	logic               page_hit;

	logic [63:0]       word;
	logic              bit_found;
	logic [5:0]        bit_sel;
	logic [SLOT_W-1:0] slot_new;
	logic [18:0]       prod;

	logic              fp_found;
	logic [PAGE_W-1:0] fp;
	logic              claim;
	logic              use_clr;

	logic [BYTES_W-1:0] meta_bytes;
	logic [SLOTS_W-1:0] meta_slots;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign cur_bytes  = class_bytes(cls_q);
	assign cur_slots  = class_slots(cls_q);
	assign meta_bytes = class_bytes(meta_rd_q.cls);
	assign meta_slots = class_slots(meta_rd_q.cls);

	always_comb begin
		sz_eff  = (req.data.req_size < MIN_REQ) ? MIN_REQ : req.data.req_size;
		cls_hit = 1'b0;
		cls_sel = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if ({21'b0, class_bytes(CLS_W'(c))} >= sz_eff) begin
				cls_hit = 1'b1;
				cls_sel = CLS_W'(c);
			end
		end
		alloc_bad = (req.data.req_size > {21'b0, max_small_q}) || !cls_hit
			|| (class_slots(cls_sel) == '0);
	end

	assign page_hit = page_in_use_q[p_q] && (meta_rd_q.cls == cls_q)
		&& (meta_rd_q.used < cur_slots);

	always_comb begin
		word      = bm_rvld_q ? bm_rd_q : '0;
		bit_found = 1'b0;
		bit_sel   = '0;
		for (int i = 63; i >= 0; i--) begin
			if (!word[i] && ({1'b0, w_q, 6'(i)} < cur_slots)) begin
				bit_found = 1'b1;
				bit_sel   = 6'(i);
			end
		end
		slot_new = {w_q, bit_sel};
		prod     = 19'(slot_new) * 19'(cur_bytes);
	end

	always_comb begin
		fp_found = 1'b0;
		fp       = '0;
		for (int i = PAGES - 1; i >= 0; i--) begin
			if (!page_in_use_q[i]) begin
				fp_found = 1'b1;
				fp       = PAGE_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.data.cmd == CMD_FREE)
						state_d = page_in_use_q[req.data.free_page] ? S_F_META : S_RES;
					else
						state_d = alloc_bad ? S_RES : S_A_RD;
				end
			end
			S_A_RD: state_d = S_A_CHK;
			S_A_CHK: begin
				if (page_hit)
					state_d = S_W_RD;
				else if (p_q == PAGE_W'(PAGES - 1))
					state_d = S_CLAIM;
			end
			S_W_RD: state_d = S_W_CHK;
			S_W_CHK: begin
				if (bit_found)
					state_d = S_RES;
				else if (w_q == WSEL_W'(WORDS_PER_PAGE - 1))
					state_d = S_CLAIM;
				else
					state_d = S_W_RD;
			end
			S_CLAIM: state_d = S_RES;
			S_F_META: begin
				if (off_q < OFF_W'(HEADER_BYTES) || meta_slots == '0)
					state_d = S_RES;
				else
					state_d = S_F_DIV;
			end
			S_F_DIV: begin
				if (div_rsp.done)
					state_d = S_F_RD;
			end
			S_F_RD: state_d = (slot_q >= OFF_W'(cur_slots)) ? S_RES : S_F_CHK;
			S_F_CHK: state_d = S_RES;
			S_RES: begin
				if (!out_valid_q || res.ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		meta_raddr  = p_q;
		meta_we     = 1'b0;
		meta_wdata  = meta_rd_q;
		bm_raddr    = {p_q, w_q};
		bm_we       = 1'b0;
		bm_waddr    = {p_q, w_q};
		bm_wdata    = word;
		claim       = 1'b0;
		use_clr     = 1'b0;
		res_load    = 1'b0;
		res_d       = '0;
		div_ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				meta_raddr = req.data.free_page;
				if (acc) begin
					res_load = 1'b1;
					if (req.data.cmd == CMD_FREE) begin
						res_d.status     = ST_NOT_OWNED;
						res_d.page_index = req.data.free_page;
					end else begin
						res_d.status = ST_TOO_LARGE;
						meta_raddr   = '0;
					end
				end
			end
			S_A_CHK: begin
				meta_raddr = page_hit ? p_q : p_q + 1'b1;
			end
			S_W_CHK: begin
				if (bit_found) begin
					bm_we                = 1'b1;
					bm_wdata             = word;
					bm_wdata[bit_sel]    = 1'b1;
					meta_we              = 1'b1;
					meta_wdata.cls       = cls_q;
					meta_wdata.used      = meta_rd_q.used + 1'b1;
					res_load             = 1'b1;
					res_d.status         = ST_OK;
					res_d.page_index     = p_q;
					res_d.byte_offset    = OFF_W'(HEADER_BYTES) + prod[OFF_W-1:0];
					res_d.size_class     = cls_q;
					res_d.slot_bytes     = cur_bytes;
				end
			end
			S_CLAIM: begin
				res_load         = 1'b1;
				res_d.size_class = cls_q;
				res_d.slot_bytes = cur_bytes;
				if (fp_found) begin
					claim             = 1'b1;
					meta_raddr        = fp;
					meta_we           = 1'b1;
					meta_wdata.cls    = cls_q;
					meta_wdata.used   = SLOTS_W'(1);
					bm_we             = 1'b1;
					bm_waddr          = {fp, WSEL_W'(0)};
					bm_wdata          = 64'd1;
					res_d.status      = ST_OK;
					res_d.page_index  = fp;
					res_d.byte_offset = OFF_W'(HEADER_BYTES);
				end else begin
					res_d.status = ST_NO_PAGE;
				end
			end
			S_F_META: begin
				div_ctl.start    = !(off_q < OFF_W'(HEADER_BYTES) || meta_slots == '0);
				div_ctl.dividend = off_q - OFF_W'(HEADER_BYTES);
				div_ctl.divisor  = meta_bytes;
				res_load         = !div_ctl.start;
				res_d.status     = ST_NOT_OWNED;
				res_d.page_index = p_q;
			end
			S_F_RD: begin
				bm_raddr         = {p_q, slot_q[SLOT_W-1:6]};
				res_load         = (slot_q >= OFF_W'(cur_slots));
				res_d.status     = ST_NOT_OWNED;
				res_d.page_index = p_q;
			end
			S_F_CHK: begin
				res_load         = 1'b1;
				res_d.page_index = p_q;
				if (word[slot_q[5:0]]) begin
					bm_we                   = 1'b1;
					bm_wdata                = word;
					bm_wdata[slot_q[5:0]]   = 1'b0;
					meta_we                 = 1'b1;
					meta_wdata.used         = (meta_rd_q.used == '0) ? '0
						: meta_rd_q.used - 1'b1;
					use_clr                 = (meta_rd_q.used <= SLOTS_W'(1));
					res_d.status            = ST_OK;
					res_d.byte_offset       = off_q - OFF_W'(rem_q);
					res_d.size_class        = cls_q;
					res_d.slot_bytes        = cur_bytes;
					res_d.page_released     = use_clr;
				end else begin
					res_d.status = ST_NOT_OWNED;
				end
			end
			default: begin
			end
		endcase
	end

	scsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.rsp    (div_rsp)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_small_q   <= MAX_SMALL_RESET;
			page_in_use_q <= '0;
			bm_valid_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready)
				max_small_q <= cfg.data;
			// word 0 of a claimed page is written, and so marked valid, below
			if (claim) begin
				page_in_use_q[fp] <= 1'b1;
				for (int w = 1; w < WORDS_PER_PAGE; w++)
					bm_valid_q[{fp, WSEL_W'(w)}] <= 1'b0;
			end
			if (use_clr)
				page_in_use_q[p_q] <= 1'b0;
			if (bm_we)
				bm_valid_q[bm_waddr] <= 1'b1;
			if (state_q == S_RES && (!out_valid_q || res.ready))
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res_d;
		if (state_q == S_RES && (!out_valid_q || res.ready))
			out_q <= res_q;
		unique case (state_q)
			S_IDLE: begin
				cls_q <= cls_sel;
				p_q   <= (req.data.cmd == CMD_FREE) ? req.data.free_page : '0;
				off_q <= req.data.free_offset;
				w_q   <= '0;
			end
			S_A_CHK: begin
				if (!page_hit)
					p_q <= p_q + 1'b1;
				w_q <= '0;
			end
			S_W_CHK: w_q <= w_q + 1'b1;
			S_F_META: cls_q <= meta_rd_q.cls;
			S_F_DIV: begin
				if (div_rsp.done) begin
					slot_q <= div_rsp.quot;
					rem_q  <= div_rsp.rem;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_raddr] <= meta_wdata;
		meta_rd_q <= meta_mem[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (bm_we)
			bm_mem[bm_waddr] <= bm_wdata;
		bm_rd_q   <= bm_mem[bm_raddr];
		bm_rvld_q <= bm_valid_q[bm_raddr];
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	a_claim_marks_page: assert property (@(posedge clk) disable iff (!arst_n)
		claim |=> page_in_use_q[$past(fp)])
		else $error("claimed page not marked in use");
	a_ok_past_header: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_d.status == ST_OK) |-> (res_d.byte_offset >= OFF_W'(HEADER_BYTES)))
		else $error("slot offset inside page header");
	a_div_only_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_F_DIV))
		else $error("divider result outside free sequence");
	a_release_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		use_clr |-> (bm_we && state_q == S_F_CHK))
		else $error("page released without a slot free");

endmodule
